/* sv/fxa_pkg.sv */
// Package: operation codes, payload structs and cell control types for the Q24.8 ALU.
`default_nettype none
package fxa_pkg;
	localparam int IO_BITS = 32;

	typedef enum logic [3:0] {
		FN_ADD = 4'd0, FN_SUB = 4'd1, FN_MUL = 4'd2, FN_DIV = 4'd3,
		FN_GT = 4'd4, FN_LT = 4'd5, FN_GE = 4'd6, FN_LE = 4'd7,
		FN_EQ = 4'd8, FN_NE = 4'd9, FN_MIN = 4'd10, FN_MAX = 4'd11,
		FN_INC = 4'd12, FN_DEC = 4'd13, FN_FROM_INT = 4'd14, FN_TO_INT = 4'd15
	} func_t;

	typedef enum logic [1:0] {
		ERR_OK = 2'd0, ERR_OVF = 2'd1, ERR_DIV0 = 2'd2
	} err_t;

	typedef struct packed {
		logic [3:0]         func;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               compare_true;
		logic [1:0]         error_code;
	} out_word_t;

	// side info carried alongside the divider row
	typedef struct packed {
		logic       vld;
		logic       neg;
		logic       is_div;
		logic       div0;
		logic       done;
		logic [1:0] err;
		logic       cmp;
	} ctl_t;
endpackage
`default_nettype wire

/* sv/fxa_cell.sv */
// Restoring divider cell: one quotient bit per stage, with passed-through result.
`default_nettype none
module fxa_cell #(
	parameter int NW = 40,
	parameter int DW = 32,
	parameter int RW = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire fxa_pkg::ctl_t   ctl_i,
	input  wire logic [NW-1:0]   num_i,
	input  wire logic [DW-1:0]   den_i,
	input  wire logic [DW:0]     rem_i,
	input  wire logic [NW-1:0]   quo_i,
	input  wire logic [RW-1:0]   res_i,
	output fxa_pkg::ctl_t        ctl_o,
	output logic [NW-1:0]        num_o,
	output logic [DW-1:0]        den_o,
	output logic [DW:0]          rem_o,
	output logic [NW-1:0]        quo_o,
	output logic [RW-1:0]        res_o
);
	import fxa_pkg::*;

	logic [DW+1:0] sh;
	logic [DW+1:0] df;
	logic          ge;

	// shift in the next numerator bit, trial subtract
	always_comb begin
		sh = {rem_i, num_i[NW-1]};
		df = sh - {2'b00, den_i};
		ge = !df[DW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_o <= {num_i[NW-2:0], 1'b0};
			den_o <= den_i;
			rem_o <= ge ? df[DW:0] : sh[DW:0];
			quo_o <= {quo_i[NW-2:0], ge};
			res_o <= res_i;
		end
	end
endmodule
`default_nettype wire

/* sv/fxa_front.sv */
// Front stage: all non-divide operations and divider operand setup.
`default_nettype none
module fxa_front #(
	parameter int FRAC_BITS = 8,
	parameter int WORD_BITS = 32
) (
	input  wire fxa_pkg::in_word_t       in_w,
	output fxa_pkg::ctl_t                ctl,
	output logic [WORD_BITS+FRAC_BITS-1:0] num,
	output logic [WORD_BITS-1:0]         den,
	output logic [WORD_BITS-1:0]         res
);
	import fxa_pkg::*;
	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int PW = 2 * W;

	logic signed [W-1:0] a, b;
	logic [W-1:0] ma, mb, s, maxp, minn, dsum, ddif;
	logic na, nb, gt, lt, eq;
	logic [PW-1:0] prod, prnd;
	logic [PW-F-1:0] pq;
	logic signed [W-1:0] hi_lim, lo_lim;

	always_comb begin
		a = W'($signed(in_w.operand_a));
		b = W'($signed(in_w.operand_b));
		na = a[W-1];
		nb = b[W-1];
		ma = na ? W'(-a) : W'(a);
		mb = nb ? W'(-b) : W'(b);
		maxp = {1'b0, {(W-1){1'b1}}};
		minn = {1'b1, {(W-1){1'b0}}};
		gt = a > b;
		lt = a < b;
		eq = a == b;
		dsum = W'(a + b);
		ddif = W'(a - b);
		prod = PW'(ma) * PW'(mb);
		prnd = prod + PW'(1 << (F - 1));
		pq = prnd[PW-1:F];
		hi_lim = W'(maxp >> F);
		lo_lim = W'(-$signed({1'b0, minn >> F}));

		ctl = '0;
		ctl.vld = 1'b1;
		ctl.done = 1'b1;
		ctl.neg = na ^ nb;
		num = {ma, {F{1'b0}}};
		den = mb;
		s = '0;
		case (func_t'(in_w.func))
			FN_ADD: begin
				s = dsum;
				if (na == nb && s[W-1] != na) begin
					ctl.err = ERR_OVF;
					s = na ? minn : maxp;
				end
			end
			FN_SUB: begin
				s = ddif;
				if (na != nb && s[W-1] != na) begin
					ctl.err = ERR_OVF;
					s = na ? minn : maxp;
				end
			end
			FN_MUL: begin
				if (pq > PW'(ctl.neg ? minn : maxp)) begin
					ctl.err = ERR_OVF;
					s = ctl.neg ? minn : maxp;
				end else begin
					s = ctl.neg ? W'(-pq) : W'(pq);
				end
			end
			FN_DIV: begin
				ctl.done = 1'b0;
				ctl.is_div = 1'b1;
				ctl.div0 = (mb == '0);
			end
			FN_GT: ctl.cmp = gt;
			FN_LT: ctl.cmp = lt;
			FN_GE: ctl.cmp = !lt;
			FN_LE: ctl.cmp = !gt;
			FN_EQ: ctl.cmp = eq;
			FN_NE: ctl.cmp = !eq;
			FN_MIN: s = gt ? b : a;
			FN_MAX: s = lt ? b : a;
			FN_INC: begin
				if (a == maxp) begin
					ctl.err = ERR_OVF;
					s = maxp;
				end else s = W'(a + 1);
			end
			FN_DEC: begin
				if (a == minn) begin
					ctl.err = ERR_OVF;
					s = minn;
				end else s = W'(a - 1);
			end
			FN_FROM_INT: begin
				if (a > hi_lim) begin
					ctl.err = ERR_OVF;
					s = maxp;
				end else if (a < lo_lim) begin
					ctl.err = ERR_OVF;
					s = minn;
				end else s = W'(a <<< F);
			end
			default: begin
				s = na ? W'(-(ma >> F)) : (ma >> F);
			end
		endcase
		res = s;
	end
endmodule
`default_nettype wire

/* sv/fixed_point_q24_8_alu_unit.sv */
// Top level: signed fixed-point ALU with a pipelined row of divider cells.
// Each operation passes the input, divider row, quotient and output registers.
// Throughput: one word per cycle unless stalled; the divider row holds one
// cell per quotient bit, and all operations share the row, so order is kept.
// Stalls freeze the whole row; in_ready follows the output register's state.
// Reset (arst_n low) clears all valid flags; payload registers are not reset.
`default_nettype none
module fixed_point_q24_8_alu_unit #(
	parameter int FRAC_BITS = 8,
	parameter int WORD_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire fxa_pkg::in_word_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output fxa_pkg::out_word_t       out_data
);
	import fxa_pkg::*;
	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int NW = W + F;

	logic en;
	ctl_t fctl, fctl_v, ctl_s1;
	logic [NW-1:0] fnum, num_s1;
	logic [W-1:0] fden, den_s1, fres, res_s1;

	ctl_t ctl_c [NW+1];
	logic [NW-1:0] num_c [NW+1];
	logic [W-1:0] den_c [NW+1];
	logic [W:0] rem_c [NW+1];
	logic [NW-1:0] quo_c [NW+1];
	logic [W-1:0] res_c [NW+1];

	ctl_t ctl_s2;
	logic [NW-1:0] quo_s2;
	logic [W-1:0] den_s2, rem_s2, res_s2;

	// row advances when the output register is free or being emptied
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	fxa_front #(.FRAC_BITS(F), .WORD_BITS(W)) u_front (
		.in_w(in_data), .ctl(fctl), .num(fnum), .den(fden), .res(fres)
	);

	// valid flag comes from the handshake, not the front stage
	always_comb begin
		fctl_v = fctl;
		fctl_v.vld = in_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s1 <= '0;
		else if (en) ctl_s1 <= fctl_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= fnum;
			den_s1 <= fden;
			res_s1 <= fres;
		end
	end

	assign ctl_c[0] = ctl_s1;
	assign num_c[0] = num_s1;
	assign den_c[0] = den_s1;
	assign rem_c[0] = '0;
	assign quo_c[0] = '0;
	assign res_c[0] = res_s1;

	for (genvar i = 0; i < NW; i++) begin : g_row
		fxa_cell #(.NW(NW), .DW(W), .RW(W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.ctl_i(ctl_c[i]), .num_i(num_c[i]), .den_i(den_c[i]),
			.rem_i(rem_c[i]), .quo_i(quo_c[i]), .res_i(res_c[i]),
			.ctl_o(ctl_c[i+1]), .num_o(num_c[i+1]), .den_o(den_c[i+1]),
			.rem_o(rem_c[i+1]), .quo_o(quo_c[i+1]), .res_o(res_c[i+1])
		);
	end

	// register the raw quotient before rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s2 <= '0;
		else if (en) ctl_s2 <= ctl_c[NW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s2 <= quo_c[NW];
			den_s2 <= den_c[NW];
			rem_s2 <= rem_c[NW][W-1:0];
			res_s2 <= res_c[NW];
		end
	end

	// round half away, saturate, sign
	logic [NW:0] qr;
	logic [W-1:0] lim, dres;
	logic derr;
	out_word_t fin;

	always_comb begin
		qr = {1'b0, quo_s2} +
			(NW+1)'(({1'b0, rem_s2} >= ({1'b0, den_s2} - {1'b0, rem_s2})) ? 1 : 0);
		lim = ctl_s2.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		derr = qr > (NW+1)'(lim);
		if (derr) dres = lim;
		else dres = ctl_s2.neg ? W'(-qr[W-1:0]) : qr[W-1:0];
		fin.compare_true = ctl_s2.cmp;
		if (!ctl_s2.is_div) begin
			fin.result_value = 32'($signed(res_s2));
			fin.error_code = ctl_s2.err;
		end else if (ctl_s2.div0) begin
			fin.result_value = '0;
			fin.error_code = ERR_DIV0;
		end else begin
			fin.result_value = 32'($signed(dres));
			fin.error_code = derr ? ERR_OVF : ERR_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= ctl_s2.vld;
	end

	always_ff @(posedge clk) begin
		if (en) out_data <= fin;
	end

	// stall must hold the output word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed under stall");
	// a true comparison never carries a result value or error
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.compare_true |-> out_data.result_value == 0 &&
		out_data.error_code == ERR_OK)
		else $error("comparison with nonzero payload");
	// no error code above divide by zero
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.error_code != 2'd3)
		else $error("bad error code");
endmodule
`default_nettype wire
